>>> hdl/fbs_pkg.sv
// package for the fec block size selector: field widths, defaults and helpers
package fbs_pkg;

  // payload field widths
  localparam int LOSS_W   = 16;
  localparam int BW_W     = 32;
  localparam int REGION_W = 2;
  localparam int FRAME_W  = 3;
  localparam int LEVEL_W  = 3;
  localparam int K_W      = 8;

  // derived datapath widths
  localparam int PROD_W  = LOSS_W + BW_W;
  localparam int WSUM_W  = PROD_W + 1;
  localparam int TOTAL_W = BW_W + 1;

  // default configuration
  localparam int LEVELS_DEF           = 7;
  localparam int REGIONS_DEF          = 4;
  localparam int FRAMES_PER_GROUP_DEF = 8;
  localparam int FRAMES_PER_STEP_DEF  = 2;

  // bound for level i is total << (i + BOUND_SHIFT)
  localparam int BOUND_SHIFT = 9;

  // source block size k = 256 - 2^(level+1)
  function automatic logic [K_W-1:0] block_size(input logic [LEVEL_W-1:0] level);
    logic [K_W:0] full;
    logic [K_W:0] step;
    step = (K_W+1)'(1) << (level + LEVEL_W'(1));
    full = {1'b1, {K_W{1'b0}}} - step;
    return full[K_W-1:0];
  endfunction

endpackage

>>> hdl/fec_block_size_selector.sv
// fec block size selector: picks a redundancy level from two paths and emits the k table
//
// usage
//   input channel: an item is taken at a rising edge where start_i is high and busy_o is
//   low. it carries loss (unsigned q0.16) and available bandwidth of two paths.
//   result channel: every item yields REGIONS*FRAMES_PER_GROUP beats (32 by default),
//   one per cycle, each marked by valid_o for exactly one cycle. order runs from the
//   last region and frame down to region 0 frame 0; last_entry_o flags the final beat.
//   the receiver cannot stall: every beat is taken in the cycle it is shown.
// pipeline and throughput
//   four register stages (multiply, sum, bound compare, level select) feed an entry
//   sequencer, and each beat leaves through an output register. the sequencer gives
//   one beat per cycle, and the output port sets the sustained rate. while it runs,
//   up to four more items are taken into the stages, then busy_o rises until the
//   sequencer frees the level-select stage. consecutive items stream with no gap
//   between their beats.
// reset
//   rst_ni clears all valid bits and the sequencer; nothing else needs clearing.
module fec_block_size_selector #(
  parameter int LEVELS           = fbs_pkg::LEVELS_DEF,
  parameter int REGIONS          = fbs_pkg::REGIONS_DEF,
  parameter int FRAMES_PER_GROUP = fbs_pkg::FRAMES_PER_GROUP_DEF,
  parameter int FRAMES_PER_STEP  = fbs_pkg::FRAMES_PER_STEP_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [fbs_pkg::LOSS_W-1:0]   channel_a_loss_i,
  input  logic [fbs_pkg::BW_W-1:0]     channel_a_bandwidth_i,
  input  logic [fbs_pkg::LOSS_W-1:0]   channel_b_loss_i,
  input  logic [fbs_pkg::BW_W-1:0]     channel_b_bandwidth_i,
  output logic                         valid_o,
  output logic [fbs_pkg::REGION_W-1:0] region_index_o,
  output logic [fbs_pkg::FRAME_W-1:0]  frame_index_o,
  output logic [fbs_pkg::LEVEL_W-1:0]  redundancy_level_o,
  output logic [fbs_pkg::K_W-1:0]      block_size_o,
  output logic                         last_entry_o
);

  // sequencer counter widths
  localparam int RCW    = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int FCW    = (FRAMES_PER_GROUP > 1) ? $clog2(FRAMES_PER_GROUP) : 1;
  localparam int FSTEPS = (FRAMES_PER_GROUP - 1) / FRAMES_PER_STEP + 1;
  localparam int FSW    = (FSTEPS > 1) ? $clog2(FSTEPS) : 1;
  localparam int SCW    = (FRAMES_PER_STEP > 1) ? $clog2(FRAMES_PER_STEP) : 1;
  localparam int SUMW   = fbs_pkg::LEVEL_W + FSW + RCW;

  localparam logic [fbs_pkg::LEVEL_W-1:0] LAST_LEVEL = fbs_pkg::LEVEL_W'(LEVELS - 1);

  // ---------------------------------------------------------------- stage control
  logic v1_q, v2_q, v3_q, hv_q;
  logic en1, en2, en3, enh;
  logic take;
  logic accept;

  assign enh    = !hv_q || take;
  assign en3    = !v3_q || enh;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;
  assign busy_o = !en1;
  assign accept = start_i && en1;

  // ---------------------------------------------------------------- stage 1: products
  logic [fbs_pkg::PROD_W-1:0]  prod_a_q, prod_b_q;
  logic [fbs_pkg::TOTAL_W-1:0] total1_q;

  // ---------------------------------------------------------------- stage 2: sums
  logic [fbs_pkg::WSUM_W-1:0]  wsum_q;
  logic [fbs_pkg::TOTAL_W-1:0] total2_q;

  // ---------------------------------------------------------------- stage 3: bounds
  logic [LEVELS-1:0] meet_d, meet_q;

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      meet_d[i] = (wsum_q <= (fbs_pkg::WSUM_W'(total2_q) << (i + fbs_pkg::BOUND_SHIFT)))
                  && (total2_q != '0);
    end
  end

  // ---------------------------------------------------------------- stage 4: base level
  logic [fbs_pkg::LEVEL_W-1:0] base_d, base_h_q;

  // first level that meets its bound, else the last one
  always_comb begin
    base_d = LAST_LEVEL;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (meet_q[i]) begin
        base_d = fbs_pkg::LEVEL_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      hv_q <= 1'b0;
    end else begin
      if (en1) v1_q <= accept;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (enh) hv_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_a_q <= fbs_pkg::PROD_W'(channel_a_loss_i) * fbs_pkg::PROD_W'(channel_a_bandwidth_i);
      prod_b_q <= fbs_pkg::PROD_W'(channel_b_loss_i) * fbs_pkg::PROD_W'(channel_b_bandwidth_i);
      total1_q <= fbs_pkg::TOTAL_W'(channel_a_bandwidth_i)
                + fbs_pkg::TOTAL_W'(channel_b_bandwidth_i);
    end
    if (en2 && v1_q) begin
      wsum_q   <= fbs_pkg::WSUM_W'(prod_a_q) + fbs_pkg::WSUM_W'(prod_b_q);
      total2_q <= total1_q;
    end
    if (en3 && v2_q) begin
      meet_q <= meet_d;
    end
    if (enh && v3_q) begin
      base_h_q <= base_d;
    end
  end

  // ---------------------------------------------------------------- entry sequencer
  logic                        act_q;
  logic [fbs_pkg::LEVEL_W-1:0] base_q;
  logic [RCW-1:0]              r_q, rfe_q;
  logic [FCW-1:0]              f_q;
  logic [FSW-1:0]              fstep_q;
  logic [SCW-1:0]              sc_q;
  logic                        fin;
  logic [SUMW-1:0]             lvl_sum;
  logic [fbs_pkg::LEVEL_W-1:0] lvl;

  assign fin  = act_q && (r_q == '0) && (f_q == '0);
  assign take = hv_q && (!act_q || fin);

  // level offset grows by one per region and by one per step of frames from the end
  assign lvl_sum = SUMW'(base_q) + SUMW'(fstep_q) + SUMW'(rfe_q);
  assign lvl     = (lvl_sum > SUMW'(LAST_LEVEL)) ? LAST_LEVEL
                                                 : fbs_pkg::LEVEL_W'(lvl_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else if (take) begin
      act_q <= 1'b1;
    end else if (fin) begin
      act_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      base_q  <= base_h_q;
      r_q     <= RCW'(REGIONS - 1);
      f_q     <= FCW'(FRAMES_PER_GROUP - 1);
      rfe_q   <= '0;
      fstep_q <= '0;
      sc_q    <= '0;
    end else if (act_q) begin
      if (f_q == '0) begin
        r_q     <= r_q - RCW'(1);
        rfe_q   <= rfe_q + RCW'(1);
        f_q     <= FCW'(FRAMES_PER_GROUP - 1);
        fstep_q <= '0;
        sc_q    <= '0;
      end else begin
        f_q <= f_q - FCW'(1);
        if (sc_q == SCW'(FRAMES_PER_STEP - 1)) begin
          sc_q    <= '0;
          fstep_q <= fstep_q + FSW'(1);
        end else begin
          sc_q <= sc_q + SCW'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------- output register
  logic                         valid_q;
  logic [fbs_pkg::REGION_W-1:0] region_q;
  logic [fbs_pkg::FRAME_W-1:0]  frame_q;
  logic [fbs_pkg::LEVEL_W-1:0]  level_q;
  logic [fbs_pkg::K_W-1:0]      k_q;
  logic                         last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= act_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act_q) begin
      region_q <= fbs_pkg::REGION_W'(r_q);
      frame_q  <= fbs_pkg::FRAME_W'(f_q);
      level_q  <= lvl;
      k_q      <= fbs_pkg::block_size(lvl);
      last_q   <= fin;
    end
  end

  assign valid_o            = valid_q;
  assign region_index_o     = region_q;
  assign frame_index_o      = frame_q;
  assign redundancy_level_o = level_q;
  assign block_size_o       = k_q;
  assign last_entry_o       = last_q;

  // ---------------------------------------------------------------- assertions
  a_level_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (redundancy_level_o <= LAST_LEVEL))
    else $error("level beyond last level");

  a_beats_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_entry_o) |=> valid_o)
    else $error("gap inside an item's beats");

  // within one region the frame offset only grows
  a_level_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_entry_o && (frame_index_o != '0))
      |=> (redundancy_level_o >= $past(redundancy_level_o)))
    else $error("level fell within a region");

  a_take_needs_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> act_q)
    else $error("sequencer did not start after taking a level");

endmodule

>>> verif/fbs_k_table_checker.sv
// checker for the fec block size selector: predicts the k table of each item and compares beats
module fbs_k_table_checker #(
  parameter int LEVELS           = fbs_pkg::LEVELS_DEF,
  parameter int REGIONS          = fbs_pkg::REGIONS_DEF,
  parameter int FRAMES_PER_GROUP = fbs_pkg::FRAMES_PER_GROUP_DEF,
  parameter int FRAMES_PER_STEP  = fbs_pkg::FRAMES_PER_STEP_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [fbs_pkg::LOSS_W-1:0]   channel_a_loss_i,
  input  logic [fbs_pkg::BW_W-1:0]     channel_a_bandwidth_i,
  input  logic [fbs_pkg::LOSS_W-1:0]   channel_b_loss_i,
  input  logic [fbs_pkg::BW_W-1:0]     channel_b_bandwidth_i,
  input  logic                         valid_i,
  input  logic [fbs_pkg::REGION_W-1:0] region_index_i,
  input  logic [fbs_pkg::FRAME_W-1:0]  frame_index_i,
  input  logic [fbs_pkg::LEVEL_W-1:0]  redundancy_level_i,
  input  logic [fbs_pkg::K_W-1:0]      block_size_i,
  input  logic                         last_entry_i,
  output int                           mismatches_o,
  output int                           pending_o
);
  import fbs_pkg::*;

  typedef struct packed {
    logic [REGION_W-1:0] region;
    logic [FRAME_W-1:0]  frame;
    logic [LEVEL_W-1:0]  level;
    logic [K_W-1:0]      k;
    logic                last;
  } k_entry_t;

  k_entry_t k_table_q[$];

  // first level whose bound holds, last level when none does
  function automatic logic [LEVEL_W-1:0] weighted_loss_level(
    input logic [LOSS_W-1:0] loss_a,
    input logic [BW_W-1:0]   bw_a,
    input logic [LOSS_W-1:0] loss_b,
    input logic [BW_W-1:0]   bw_b
  );
    logic [63:0] weighted;
    logic [63:0] total;
    weighted = 64'(loss_a) * 64'(bw_a) + 64'(loss_b) * 64'(bw_b);
    total    = 64'(bw_a) + 64'(bw_b);
    if (total == 64'd0) return LEVEL_W'(LEVELS - 1);
    for (int lv = 0; lv < LEVELS; lv++) begin
      if (weighted <= (total << (lv + BOUND_SHIFT))) return LEVEL_W'(lv);
    end
    return LEVEL_W'(LEVELS - 1);
  endfunction

  // one entry per region and frame, last region and frame first
  task automatic queue_k_table(input logic [LEVEL_W-1:0] base);
    int lv;
    k_entry_t entry;
    for (int r = REGIONS - 1; r >= 0; r--) begin
      for (int f = FRAMES_PER_GROUP - 1; f >= 0; f--) begin
        lv = int'(base) + (FRAMES_PER_GROUP - 1 - f) / FRAMES_PER_STEP + (REGIONS - 1 - r);
        if (lv > LEVELS - 1) lv = LEVELS - 1;
        entry.region = REGION_W'(r);
        entry.frame  = FRAME_W'(f);
        entry.level  = LEVEL_W'(lv);
        entry.k      = K_W'(256 - (1 << (lv + 1)));
        entry.last   = (r == 0 && f == 0);
        k_table_q.push_back(entry);
      end
    end
  endtask

  task automatic flag_mismatch(input string msg);
    $display("[%0t] k table mismatch: %s", $time, msg);
    mismatches_o++;
  endtask

  always @(posedge clk_i) begin
    k_entry_t want;
    if (rst_ni) begin
      if (valid_i === 1'b1) begin
        if (k_table_q.size() == 0) begin
          flag_mismatch($sformatf("beat with no entry pending (region %0d frame %0d)",
                                  region_index_i, frame_index_i));
        end else begin
          want = k_table_q.pop_front();
          if (region_index_i !== want.region)
            flag_mismatch($sformatf("region_index got %0d expected %0d",
                                    region_index_i, want.region));
          if (frame_index_i !== want.frame)
            flag_mismatch($sformatf("frame_index got %0d expected %0d",
                                    frame_index_i, want.frame));
          if (redundancy_level_i !== want.level)
            flag_mismatch($sformatf("redundancy_level got %0d expected %0d",
                                    redundancy_level_i, want.level));
          if (block_size_i !== want.k)
            flag_mismatch($sformatf("block_size got %0d expected %0d",
                                    block_size_i, want.k));
          if (last_entry_i !== want.last)
            flag_mismatch($sformatf("last_entry got %0d expected %0d",
                                    last_entry_i, want.last));
        end
      end
      if (start_i && !busy_i) begin
        queue_k_table(weighted_loss_level(channel_a_loss_i, channel_a_bandwidth_i,
                                          channel_b_loss_i, channel_b_bandwidth_i));
      end
      pending_o <= k_table_q.size();
    end
  end

endmodule

>>> verif/tb_fec_block_size_selector.sv
// testbench top for the fec block size selector: stimulus, watchdog and verdict
module tb_fec_block_size_selector;
  import fbs_pkg::*;

  // cycles with no accepted item and no result beat before the run is called hung
  localparam int IDLE_LIMIT = 1000;
  // settle time after the last beat, well past the pipeline latency
  localparam int TAIL_CYCLES = 16;
  localparam int RANDOM_ITEMS = 220;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic [LOSS_W-1:0]   channel_a_loss_i = '0;
  logic [BW_W-1:0]     channel_a_bandwidth_i = '0;
  logic [LOSS_W-1:0]   channel_b_loss_i = '0;
  logic [BW_W-1:0]     channel_b_bandwidth_i = '0;
  logic                busy_o;
  logic                valid_o;
  logic [REGION_W-1:0] region_index_o;
  logic [FRAME_W-1:0]  frame_index_o;
  logic [LEVEL_W-1:0]  redundancy_level_o;
  logic [K_W-1:0]      block_size_o;
  logic                last_entry_o;

  int mismatches;
  int pending;
  int idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  fec_block_size_selector dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .start_i               (start_i),
    .busy_o                (busy_o),
    .channel_a_loss_i      (channel_a_loss_i),
    .channel_a_bandwidth_i (channel_a_bandwidth_i),
    .channel_b_loss_i      (channel_b_loss_i),
    .channel_b_bandwidth_i (channel_b_bandwidth_i),
    .valid_o               (valid_o),
    .region_index_o        (region_index_o),
    .frame_index_o         (frame_index_o),
    .redundancy_level_o    (redundancy_level_o),
    .block_size_o          (block_size_o),
    .last_entry_o          (last_entry_o)
  );

  // the checker sees both channels, predicts every entry and counts mismatches
  fbs_k_table_checker u_checker (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .start_i               (start_i),
    .busy_i                (busy_o),
    .channel_a_loss_i      (channel_a_loss_i),
    .channel_a_bandwidth_i (channel_a_bandwidth_i),
    .channel_b_loss_i      (channel_b_loss_i),
    .channel_b_bandwidth_i (channel_b_bandwidth_i),
    .valid_i               (valid_o),
    .region_index_i        (region_index_o),
    .frame_index_i         (frame_index_o),
    .redundancy_level_i    (redundancy_level_o),
    .block_size_i          (block_size_o),
    .last_entry_i          (last_entry_o),
    .mismatches_o          (mismatches),
    .pending_o             (pending)
  );

  // watchdog: any accepted item or result beat restarts the count
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // present one item and hold it until the block takes it; start stays high on return
  task automatic send_feedback(
    input logic [LOSS_W-1:0] loss_a,
    input logic [BW_W-1:0]   bw_a,
    input logic [LOSS_W-1:0] loss_b,
    input logic [BW_W-1:0]   bw_b
  );
    start_i               <= 1'b1;
    channel_a_loss_i      <= loss_a;
    channel_a_bandwidth_i <= bw_a;
    channel_b_loss_i      <= loss_b;
    channel_b_bandwidth_i <= bw_b;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic hold_off(input int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // stop sending until every predicted entry has come out
  // first edge lets the pending count catch the item taken just now
  task automatic drain_k_table();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // loss spread over the whole range, near the level bounds, and at the ends
  function automatic logic [LOSS_W-1:0] pick_loss();
    int k;
    k = $urandom_range(0, 6);
    case ($urandom_range(0, 3))
      0: return LOSS_W'($urandom);
      1: return LOSS_W'($urandom_range(0, 1 << (k + BOUND_SHIFT)));
      2: return LOSS_W'((1 << (k + BOUND_SHIFT)) - 1 + $urandom_range(0, 2));
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  // mostly full range bandwidth, some thin, idle or nearly full paths
  function automatic logic [BW_W-1:0] pick_bandwidth();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return BW_W'($urandom);
      4, 5:       return BW_W'($urandom_range(0, 255));
      6:          return '0;
      default:    return 32'hFFFF_FFFF - BW_W'($urandom_range(0, 3));
    endcase
  endfunction

  initial begin
    logic quiet;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    send_feedback(16'd0, 32'd0, 16'd0, 32'd0);              // zero total bandwidth
    send_feedback(16'hFFFF, 32'd0, 16'hFFFF, 32'd0);        // zero bandwidth, full loss
    send_feedback(16'hFFFF, '1, 16'hFFFF, '1);              // loss near one, no level met
    send_feedback(16'd0, '1, 16'd0, '1);                    // lossless wide paths
    // exactly on each level bound but the last, then one above it
    for (int k = 0; k < 6; k++) begin
      send_feedback(LOSS_W'(1 << (k + BOUND_SHIFT)), 32'd1000,
                    LOSS_W'(1 << (k + BOUND_SHIFT)), 32'd1000);
      send_feedback(LOSS_W'((1 << (k + BOUND_SHIFT)) + 1), 32'd1000,
                    LOSS_W'((1 << (k + BOUND_SHIFT)) + 1), 32'd1000);
    end
    send_feedback(16'd0, 32'd0, 16'd600, 32'd1000);         // one path idle
    send_feedback(16'hFFFF, 32'd1, 16'd0, '1);              // lossy thin path beside a clean one
    send_feedback(16'h8000, '1, 16'h7FFF, 32'd0);           // last bound met exactly
    send_feedback(16'h5555, 32'hAAAA_AAAA, 16'hAAAA, 32'h5555_5555);
    drain_k_table();

    // random part, with a stretch of back to back items and one full drain midway
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= 60 && i < 100);
      if (i == RANDOM_ITEMS / 2) drain_k_table();
      if (!quiet && $urandom_range(0, 99) < 26) hold_off($urandom_range(1, 40));
      send_feedback(pick_loss(), pick_bandwidth(), pick_loss(), pick_bandwidth());
    end

    drain_k_table();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
